FILE: sv/trilateration_2d_three_anchor_assert.svh
// Assertion macros used by the checker module of the trilateration block.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef TRILATERATION_2D_THREE_ANCHOR_ASSERT_SVH
`define TRILATERATION_2D_THREE_ANCHOR_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define T2D_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define T2D_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: sv/tri2d_pkg.sv
`default_nettype none
package tri2d_pkg;

	// Coordinate width used inside the solver and fraction bits of the result.
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;

	// Port field widths.
	localparam int IW = 16;
	localparam int PW = 32;

	// Derived internal widths.
	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 2;          // 2*(difference of coordinates)
	localparam int SQW  = 2 * CW;          // square of a coordinate
	localparam int CFW  = 2 * CW + 3;      // right-hand sides c and f
	localparam int DENW = 2 * DW;          // denominator
	localparam int NUMW = CFW + DW;        // numerators
	localparam int DMW  = DENW - 1;        // denominator magnitude
	localparam int NMW  = NUMW - 1;        // numerator magnitude
	localparam int MW   = NMW + FRAC_BITS; // scaled numerator magnitude
	localparam int MXW  = (MW > PW) ? MW : PW + 1;
	localparam int HW   = MXW - PW;        // dividend bits above the quotient
	localparam int CMPW = (HW > DMW) ? HW : DMW;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = QAW + 1;

	localparam logic [IW-1:0] IN_MASK = (COORD_WIDTH >= IW) ? {IW{1'b1}} :
		IW'((1 << COORD_WIDTH) - 1);

	typedef struct packed {
		logic [IW-1:0] anchor0_x;
		logic [IW-1:0] anchor0_y;
		logic [IW-1:0] anchor0_range;
		logic [IW-1:0] anchor1_x;
		logic [IW-1:0] anchor1_y;
		logic [IW-1:0] anchor1_range;
		logic [IW-1:0] anchor2_x;
		logic [IW-1:0] anchor2_y;
		logic [IW-1:0] anchor2_range;
	} in_t;

	typedef struct packed {
		logic signed [PW-1:0] pos_x;
		logic signed [PW-1:0] pos_y;
		logic                 degenerate;
		logic                 saturated;
	} out_t;

	// One division job: partial remainders, dividend/quotient shift words,
	// the divisor magnitude and the sign and overflow flags.
	typedef struct packed {
		logic [DMW-1:0] rem_x;
		logic [PW-1:0]  mq_x;
		logic [DMW-1:0] rem_y;
		logic [PW-1:0]  mq_y;
		logic [DMW-1:0] den;
		logic           neg_x;
		logic           neg_y;
		logic           ovf_x;
		logic           ovf_y;
		logic           degen;
	} div_op_t;

endpackage
`default_nettype wire

FILE: sv/tri2d_front.sv
`default_nettype none
module tri2d_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              item_valid,
	input  wire tri2d_pkg::in_t    item,
	output logic                   push,
	output tri2d_pkg::div_op_t     op
);
	import tri2d_pkg::*;

	logic [CW-1:0]         cval [9];
	logic signed [CW:0]    dx01, dy01, dx12, dy12;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0]  a_s1, b_s1, d_s1, e_s1;
	logic [SQW-1:0]        sq_s1 [9];
	logic signed [DW-1:0]  a_s2, b_s2, d_s2, e_s2;
	logic signed [CFW-1:0] c_s2, f_s2;
	logic signed [DENW-1:0] ea_s3, bd_s3;
	logic signed [NUMW-1:0] ce_s3, fb_s3, cd_s3, af_s3;
	logic signed [DENW-1:0] den_s4;
	logic signed [NUMW-1:0] nx_s4, ny_s4;
	logic [DMW-1:0]        dmag_s5;
	logic [NMW-1:0]        nxmag_s5, nymag_s5;
	logic                  sd_s5, sx_s5, sy_s5, zero_s5;

	logic [MXW-1:0]        mx, my;
	logic [HW-1:0]         hx, hy;

	// Masked coordinates in the order of the item fields.
	always_comb begin
		cval[0] = CW'(item.anchor0_x & IN_MASK);
		cval[1] = CW'(item.anchor0_y & IN_MASK);
		cval[2] = CW'(item.anchor0_range & IN_MASK);
		cval[3] = CW'(item.anchor1_x & IN_MASK);
		cval[4] = CW'(item.anchor1_y & IN_MASK);
		cval[5] = CW'(item.anchor1_range & IN_MASK);
		cval[6] = CW'(item.anchor2_x & IN_MASK);
		cval[7] = CW'(item.anchor2_y & IN_MASK);
		cval[8] = CW'(item.anchor2_range & IN_MASK);
		dx01 = $signed({1'b0, cval[3]}) - $signed({1'b0, cval[0]});
		dy01 = $signed({1'b0, cval[4]}) - $signed({1'b0, cval[1]});
		dx12 = $signed({1'b0, cval[6]}) - $signed({1'b0, cval[3]});
		dy12 = $signed({1'b0, cval[7]}) - $signed({1'b0, cval[4]});
	end

	// Stage valid bits; the whole front moves together when enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: coefficient differences and squares of all inputs.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= {dx01, 1'b0};
			b_s1 <= {dy01, 1'b0};
			d_s1 <= {dx12, 1'b0};
			e_s1 <= {dy12, 1'b0};
			for (int i = 0; i < 9; i++) begin
				sq_s1[i] <= cval[i] * cval[i];
			end
		end
	end

	// Stage 2: right-hand sides of the two linear equations.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			d_s2 <= d_s1;
			e_s2 <= e_s1;
			c_s2 <= CFW'(sq_s1[2]) - CFW'(sq_s1[5]) - CFW'(sq_s1[0])
				+ CFW'(sq_s1[3]) - CFW'(sq_s1[1]) + CFW'(sq_s1[4]);
			f_s2 <= CFW'(sq_s1[5]) - CFW'(sq_s1[8]) - CFW'(sq_s1[3])
				+ CFW'(sq_s1[6]) - CFW'(sq_s1[4]) + CFW'(sq_s1[7]);
		end
	end

	// Stage 3: the six cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			ea_s3 <= e_s2 * a_s2;
			bd_s3 <= b_s2 * d_s2;
			ce_s3 <= c_s2 * e_s2;
			fb_s3 <= f_s2 * b_s2;
			cd_s3 <= c_s2 * d_s2;
			af_s3 <= a_s2 * f_s2;
		end
	end

	// Stage 4: denominator and numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= ea_s3 - bd_s3;
			nx_s4  <= ce_s3 - fb_s3;
			ny_s4  <= cd_s3 - af_s3;
		end
	end

	// Stage 5: magnitudes, signs and the collinear check.
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s5  <= DMW'(den_s4[DENW-1] ? -den_s4 : den_s4);
			nxmag_s5 <= NMW'(nx_s4[NUMW-1] ? -nx_s4 : nx_s4);
			nymag_s5 <= NMW'(ny_s4[NUMW-1] ? -ny_s4 : ny_s4);
			sd_s5    <= den_s4[DENW-1];
			sx_s5    <= nx_s4[NUMW-1];
			sy_s5    <= ny_s4[NUMW-1];
			zero_s5  <= (den_s4 == '0);
		end
	end

	// Divider setup: scale the numerators and flag quotients of 2^PW or more.
	always_comb begin
		mx = MXW'(nxmag_s5) << FRAC_BITS;
		my = MXW'(nymag_s5) << FRAC_BITS;
		hx = mx[MXW-1:PW];
		hy = my[MXW-1:PW];
		op.rem_x = DMW'(hx);
		op.mq_x  = mx[PW-1:0];
		op.rem_y = DMW'(hy);
		op.mq_y  = my[PW-1:0];
		op.den   = dmag_s5;
		op.neg_x = sx_s5 ^ sd_s5;
		op.neg_y = sy_s5 ^ ~sd_s5;
		op.ovf_x = CMPW'(hx) >= CMPW'(dmag_s5);
		op.ovf_y = CMPW'(hy) >= CMPW'(dmag_s5);
		op.degen = zero_s5;
		push     = v_s5 & en;
	end

endmodule
`default_nettype wire

FILE: sv/tri2d_queue.sv
`default_nettype none
module tri2d_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tri2d_pkg::div_op_t wdata,
	input  wire logic               pop,
	output logic                    full,
	output logic                    nonempty,
	output tri2d_pkg::div_op_t      rdata
);
	import tri2d_pkg::*;

	div_op_t        mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QCW-1:0] cnt_q;
	logic           do_pop;

	always_comb begin
		full     = (cnt_q == QCW'(QDEPTH));
		nonempty = (cnt_q != '0);
		rdata    = mem_q[rptr_q];
		do_pop   = pop & nonempty;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

FILE: sv/tri2d_back.sv
`default_nettype none
module tri2d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               op_valid,
	input  wire tri2d_pkg::div_op_t op,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output tri2d_pkg::out_t         result
);
	import tri2d_pkg::*;

	localparam logic [PW-1:0] MINV = {1'b1, {(PW-1){1'b0}}};
	localparam logic [PW-1:0] MAXV = ~MINV;

	div_op_t     op_s  [PW+1];
	logic        vld_s [PW+1];
	logic        adv;
	logic        valid_q;
	out_t        result_q;
	out_t        fin;
	logic        sat_x, sat_y;
	logic [PW-1:0] qx, qy;

	// One restoring step: shift in a dividend bit, subtract if it fits.
	function automatic logic [DMW+PW-1:0] div_step(input logic [DMW-1:0] rem,
		input logic [PW-1:0] mq, input logic [DMW-1:0] den);
		logic [DMW:0] tmp;
		logic         ge;
		tmp = {rem, mq[PW-1]};
		ge  = tmp >= {1'b0, den};
		if (ge) begin
			tmp = tmp - {1'b0, den};
		end
		div_step = {tmp[DMW-1:0], mq[PW-2:0], ge};
	endfunction

	// One divider stage: both coordinates take one step, the rest passes along.
	function automatic div_op_t step_op(input div_op_t cur);
		div_op_t nxt;
		nxt = cur;
		{nxt.rem_x, nxt.mq_x} = div_step(cur.rem_x, cur.mq_x, cur.den);
		{nxt.rem_y, nxt.mq_y} = div_step(cur.rem_y, cur.mq_y, cur.den);
		return nxt;
	endfunction

	// The divider moves unless a finished result is held by the receiver.
	always_comb begin
		adv = ~(valid_q & result_stall);
		pop = adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= PW; k++) begin
				vld_s[k] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= op_valid;
			for (int k = 0; k < PW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			valid_q <= vld_s[PW];
		end
	end

	// Divider stages, one quotient bit of each coordinate per stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0] <= op;
			for (int k = 0; k < PW; k++) begin
				op_s[k+1] <= step_op(op_s[k]);
			end
		end
	end

	// Sign, saturation and the collinear case.
	always_comb begin
		qx    = op_s[PW].mq_x;
		qy    = op_s[PW].mq_y;
		sat_x = op_s[PW].ovf_x | (op_s[PW].neg_x ? (qx > MINV) : qx[PW-1]);
		sat_y = op_s[PW].ovf_y | (op_s[PW].neg_y ? (qy > MINV) : qy[PW-1]);
		if (op_s[PW].degen) begin
			fin.pos_x      = '0;
			fin.pos_y      = '0;
			fin.degenerate = 1'b1;
			fin.saturated  = 1'b0;
		end else begin
			fin.pos_x = sat_x ? (op_s[PW].neg_x ? MINV : MAXV) :
				(op_s[PW].neg_x ? -qx : qx);
			fin.pos_y = sat_y ? (op_s[PW].neg_y ? MINV : MAXV) :
				(op_s[PW].neg_y ? -qy : qy);
			fin.degenerate = 1'b0;
			fin.saturated  = sat_x | sat_y;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= fin;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

FILE: sv/trilateration_2d_three_anchor.sv
// Planar trilateration from three anchors.
// Input channel (item_valid, item_stall, item): one item carries the x, y
// position of three anchors and the measured range to each, all unsigned.
// Output channel (result_valid, result_stall, result): one result per item,
// the tag position in signed fixed point with eight fraction bits, plus the
// degenerate flag (collinear anchors, position zero) and the saturated flag
// (a quotient clipped to 32 bits).
// Throughput is one item per cycle while the receiver does not stall: five
// front stages form the linear system, a four-entry queue buffers the
// divider jobs, an input register feeds a 32-stage restoring divider
// pipeline that produces one quotient bit of each coordinate per stage,
// followed by the output register.
// When the receiver stalls, the divider and output register hold; the front
// keeps accepting until the queue is full, then raises item_stall.
// Reset clears all valid bits and the queue; no result is pending afterward.
`default_nettype none
module trilateration_2d_three_anchor (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire tri2d_pkg::in_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output tri2d_pkg::out_t      result
);
	import tri2d_pkg::*;

	logic    q_full, q_nonempty, push, pop;
	div_op_t op_in, op_out;

	assign item_stall = q_full;

	tri2d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (~q_full),
		.item_valid (item_valid),
		.item       (item),
		.push       (push),
		.op         (op_in)
	);

	tri2d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (op_in),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rdata    (op_out)
	);

	tri2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (q_nonempty),
		.op           (op_out),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

FILE: sv/tri2d_check.sv
`default_nettype none
`include "trilateration_2d_three_anchor_assert.svh"
module tri2d_check (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            result_valid,
	input wire logic            result_stall,
	input wire tri2d_pkg::out_t result
);
	import tri2d_pkg::*;

	// A held result stays valid and unchanged.
	`T2D_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// Collinear anchors give position zero and no saturation.
	`T2D_ASSERT_NOW(a_degen, result_valid && result.degenerate, result.pos_x == 0 && result.pos_y == 0 && !result.saturated, "degenerate result not cleared")

	// A saturated result has a coordinate at a range limit.
	`T2D_ASSERT_NOW(a_sat, result_valid && result.saturated, result.pos_x == 32'sh7fffffff || result.pos_x == 32'sh80000000 || result.pos_y == 32'sh7fffffff || result.pos_y == 32'sh80000000, "saturated flag without clipped value")

endmodule

bind trilateration_2d_three_anchor tri2d_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
